// ===== sv/drbtq_pkg.sv =====
package drbtq_pkg;

    localparam int CMD_W     = 2;
    localparam int CORE_W    = 6;
    localparam int OFFSET_W  = 14;
    localparam int TAG_W     = 5;
    localparam int ROW_W     = 10;
    localparam int PHASE_W   = 3;
    localparam int DELAY_W   = 8;
    localparam int ROW_CNT_W = DELAY_W + 1;

    // Address map: partition per core, fixed row length
    localparam int PARTITION_WORDS = 16384;
    localparam int ROW_WORDS       = 1024;
    localparam int ADDR_W          = 22;

    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd2;

    localparam logic [PHASE_W-1:0] PH_IDLE       = 3'd0;
    localparam logic [PHASE_W-1:0] PH_WRITE_BACK = 3'd1;
    localparam logic [PHASE_W-1:0] PH_ROW_LOAD   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_COLUMN     = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DONE       = 3'd4;

    localparam logic CFG_ROW_DELAY    = 1'b0;
    localparam logic CFG_COLUMN_DELAY = 1'b1;

    localparam logic [DELAY_W-1:0] ROW_DELAY_RESET    = 8'd10;
    localparam logic [DELAY_W-1:0] COLUMN_DELAY_RESET = 8'd2;

    typedef struct packed {
        logic [CORE_W-1:0]   core;
        logic [OFFSET_W-1:0] offset;
        logic                is_store;
        logic [TAG_W-1:0]    tag;
    } req_t;

    // Controller to datapath, all qualified by take
    typedef struct packed {
        logic               take;
        logic               push;
        logic               push_front;
        logic               pop;
        logic               open_new;
        logic               save_prev;
        logic               drop;
        logic [PHASE_W-1:0] phase;
    } dp_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic row_hit;
    } dp_stat_t;

    function automatic logic [ADDR_W-1:0] req_addr(req_t r);
        return ADDR_W'(r.core) * ADDR_W'(PARTITION_WORDS) + ADDR_W'(r.offset);
    endfunction

    function automatic logic [ROW_W-1:0] req_row(req_t r);
        logic [ADDR_W-1:0] a;
        a = req_addr(r);
        return ROW_W'(a / ROW_WORDS);
    endfunction

    function automatic logic [ROW_W-1:0] req_col(req_t r);
        logic [ADDR_W-1:0] a;
        a = req_addr(r);
        return ROW_W'(a % ROW_WORDS);
    endfunction

endpackage

// ===== sv/dram_row_buffer_timing_queue.sv =====
// Latency: the result of a tick is shown in the cycle after its transfer in.
// Throughput: one tick per cycle; in_stall rises only while a shown result is
// held by out_stall.
// Reset clears the queue count, the wait counters and the row buffer state,
// and loads row_delay 10 and column_delay 2; queue entries are not cleared.
module dram_row_buffer_timing_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [drbtq_pkg::CMD_W-1:0]    cmd,
    input  logic [drbtq_pkg::CORE_W-1:0]   req_core,
    input  logic [drbtq_pkg::OFFSET_W-1:0] req_offset,
    input  logic                           req_is_store,
    input  logic [drbtq_pkg::TAG_W-1:0]    req_tag,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [drbtq_pkg::PHASE_W-1:0]  phase,
    output logic [drbtq_pkg::ROW_W-1:0]    shown_row,
    output logic [drbtq_pkg::ROW_W-1:0]    shown_column,
    output logic [drbtq_pkg::CORE_W-1:0]   done_core,
    output logic [drbtq_pkg::OFFSET_W-1:0] done_offset,
    output logic                           done_is_store,
    output logic [drbtq_pkg::TAG_W-1:0]    done_tag,
    output logic                           dropped,
    output logic                           queue_busy,
    input  logic                           cfg_write,
    input  logic                           cfg_index,
    input  logic [drbtq_pkg::DELAY_W-1:0]  cfg_data
);
    import drbtq_pkg::*;

    dp_cmd_t  ctl;
    dp_stat_t stat;
    req_t     new_req;

    assign new_req.core     = req_core;
    assign new_req.offset   = req_offset;
    assign new_req.is_store = req_is_store;
    assign new_req.tag      = req_tag;

    drbtq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .ctl       (ctl)
    );

    drbtq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .stat          (stat),
        .new_req       (new_req),
        .phase         (phase),
        .shown_row     (shown_row),
        .shown_column  (shown_column),
        .done_core     (done_core),
        .done_offset   (done_offset),
        .done_is_store (done_is_store),
        .done_tag      (done_tag),
        .dropped       (dropped),
        .queue_busy    (queue_busy)
    );

endmodule

// ===== sv/drbtq_dp.sv =====
module drbtq_dp #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  drbtq_pkg::dp_cmd_t            ctl,
    output drbtq_pkg::dp_stat_t           stat,
    input  drbtq_pkg::req_t               new_req,
    output logic [drbtq_pkg::PHASE_W-1:0] phase,
    output logic [drbtq_pkg::ROW_W-1:0]   shown_row,
    output logic [drbtq_pkg::ROW_W-1:0]   shown_column,
    output logic [drbtq_pkg::CORE_W-1:0]  done_core,
    output logic [drbtq_pkg::OFFSET_W-1:0] done_offset,
    output logic                          done_is_store,
    output logic [drbtq_pkg::TAG_W-1:0]   done_tag,
    output logic                          dropped,
    output logic                          queue_busy
);
    import drbtq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    req_t             q_reg  [QUEUE_DEPTH];
    req_t             q_add  [QUEUE_DEPTH];
    req_t             q_next [QUEUE_DEPTH];
    logic [CNT_W-1:0] count_reg, count_next;
    logic [ROW_W-1:0] open_row_reg, open_row_next;
    logic [ROW_W-1:0] prev_row_reg, prev_row_next;
    req_t             head;
    logic [ROW_W-1:0] head_row, head_col;

    logic [PHASE_W-1:0] phase_reg;
    logic [ROW_W-1:0]   shown_row_reg, shown_column_reg;
    req_t               done_reg;
    logic               dropped_reg, busy_reg;

    // Head as seen after this tick's enqueue
    assign head     = (count_reg == '0) ? new_req : q_reg[0];
    assign head_row = req_row(head);
    assign head_col = req_col(head);

    assign stat.empty   = (count_reg == '0);
    assign stat.full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.row_hit = (head_row == open_row_reg);

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            q_add[i] = q_reg[i];
            if (ctl.push)
            begin
                if (ctl.push_front)
                begin
                    // open a gap behind the head
                    if (i == 1)
                        q_add[i] = new_req;
                    else if (i > 1 && CNT_W'(i) <= count_reg)
                        q_add[i] = q_reg[(i > 0) ? i - 1 : 0];
                end
                else if (CNT_W'(i) == count_reg)
                begin
                    q_add[i] = new_req;
                end
            end
        end
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            q_next[i] = ctl.pop ? q_add[(i < QUEUE_DEPTH - 1) ? i + 1 : i] : q_add[i];
        end
    end

    assign count_next    = count_reg + CNT_W'(ctl.push) - CNT_W'(ctl.pop);
    assign open_row_next = ctl.open_new ? head_row : open_row_reg;
    assign prev_row_next = ctl.save_prev ? open_row_reg : prev_row_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.take)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
                q_reg[i] <= q_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            open_row_reg <= '0;
            prev_row_reg <= '0;
        end
        else if (ctl.take)
        begin
            count_reg    <= count_next;
            open_row_reg <= open_row_next;
            prev_row_reg <= prev_row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.take)
        begin
            phase_reg        <= ctl.phase;
            dropped_reg      <= ctl.drop;
            busy_reg         <= (count_next != '0);
            shown_row_reg    <= '0;
            shown_column_reg <= '0;
            done_reg         <= '0;
            case (ctl.phase)
                PH_WRITE_BACK: shown_row_reg <= prev_row_next;
                PH_ROW_LOAD:   shown_row_reg <= open_row_next;
                PH_COLUMN:     shown_column_reg <= head_col;
                PH_DONE:
                begin
                    shown_column_reg <= head_col;
                    done_reg         <= head;
                end
                default: ;
            endcase
        end
    end

    assign phase         = phase_reg;
    assign shown_row     = shown_row_reg;
    assign shown_column  = shown_column_reg;
    assign done_core     = done_reg.core;
    assign done_offset   = done_reg.offset;
    assign done_is_store = done_reg.is_store;
    assign done_tag      = done_reg.tag;
    assign dropped       = dropped_reg;
    assign queue_busy    = busy_reg;

endmodule

// ===== sv/drbtq_ctrl.sv =====
module drbtq_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [drbtq_pkg::CMD_W-1:0]   cmd,
    output logic                          out_valid,
    input  logic                          out_stall,
    input  logic                          cfg_write,
    input  logic                          cfg_index,
    input  logic [drbtq_pkg::DELAY_W-1:0] cfg_data,
    input  drbtq_pkg::dp_stat_t           stat,
    output drbtq_pkg::dp_cmd_t            ctl
);
    import drbtq_pkg::*;

    localparam logic ST_EMPTY = 1'b0;
    localparam logic ST_FULL  = 1'b1;

    logic                 state_reg, state_next;
    logic [DELAY_W-1:0]   row_delay_reg, column_delay_reg;
    logic [ROW_CNT_W-1:0] row_left_reg, row_left_next, row_left_mid;
    logic [DELAY_W-1:0]   col_wait_reg, col_wait_next, col_wait_mid, col_wait_dec;
    logic                 row_open_reg, row_open_next;
    logic [DELAY_W-1:0]   col_delay_eff;
    logic                 take, is_req, has_head;

    assign in_stall      = (state_reg == ST_FULL) && out_stall;
    assign out_valid     = (state_reg == ST_FULL);
    assign take          = in_valid && !in_stall;
    assign is_req        = (cmd == CMD_APPEND) || (cmd == CMD_INSERT);
    assign col_delay_eff = (column_delay_reg == '0) ? DELAY_W'(1) : column_delay_reg;

    always_comb
    begin
        ctl           = '0;
        ctl.phase     = PH_IDLE;
        has_head      = 1'b0;
        row_left_mid  = row_left_reg;
        col_wait_mid  = col_wait_reg;
        col_wait_dec  = col_wait_reg;
        row_left_next = row_left_reg;
        col_wait_next = col_wait_reg;
        row_open_next = row_open_reg;
        if (take)
        begin
            ctl.take       = 1'b1;
            ctl.drop       = is_req && stat.full;
            ctl.push       = is_req && !stat.full;
            ctl.push_front = ctl.push && (cmd == CMD_INSERT) && !stat.empty;
            has_head       = !stat.empty || ctl.push;
            if (has_head)
            begin
                // start timing a fresh head request
                if (row_left_reg == '0 && col_wait_reg == '0)
                begin
                    if (!row_open_reg)
                    begin
                        ctl.open_new  = 1'b1;
                        row_open_next = 1'b1;
                        row_left_mid  = {1'b0, row_delay_reg};
                    end
                    else if (stat.row_hit)
                    begin
                        row_left_mid = '0;
                    end
                    else
                    begin
                        ctl.save_prev = 1'b1;
                        ctl.open_new  = 1'b1;
                        row_left_mid  = {row_delay_reg, 1'b0};
                    end
                    col_wait_mid = col_delay_eff;
                end
                row_left_next = row_left_mid;
                col_wait_next = col_wait_mid;
                if (row_left_mid > {1'b0, row_delay_reg})
                begin
                    row_left_next = row_left_mid - 1'b1;
                    ctl.phase     = PH_WRITE_BACK;
                end
                else if (row_left_mid != '0)
                begin
                    row_left_next = row_left_mid - 1'b1;
                    ctl.phase     = PH_ROW_LOAD;
                end
                else
                begin
                    col_wait_dec  = (col_wait_mid != '0) ? col_wait_mid - 1'b1 : col_wait_mid;
                    col_wait_next = col_wait_dec;
                    if (col_wait_dec == '0)
                    begin
                        ctl.phase = PH_DONE;
                        ctl.pop   = 1'b1;
                    end
                    else
                    begin
                        ctl.phase = PH_COLUMN;
                    end
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_EMPTY:
                if (take)
                    state_next = ST_FULL;
            ST_FULL:
                if (take)
                    state_next = ST_FULL;
                else if (!out_stall)
                    state_next = ST_EMPTY;
            default: state_next = ST_EMPTY;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_EMPTY;
            row_left_reg     <= '0;
            col_wait_reg     <= '0;
            row_open_reg     <= 1'b0;
            row_delay_reg    <= ROW_DELAY_RESET;
            column_delay_reg <= COLUMN_DELAY_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            row_left_reg <= row_left_next;
            col_wait_reg <= col_wait_next;
            row_open_reg <= row_open_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_ROW_DELAY:    row_delay_reg    <= cfg_data;
                    CFG_COLUMN_DELAY: column_delay_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== sv/drbtq_checker.sv =====
module drbtq_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [drbtq_pkg::PHASE_W-1:0]  phase,
    input logic [drbtq_pkg::CORE_W-1:0]   done_core,
    input logic [drbtq_pkg::OFFSET_W-1:0] done_offset,
    input logic                           done_is_store,
    input logic [drbtq_pkg::TAG_W-1:0]    done_tag,
    input logic                           dropped,
    input logic                           queue_busy
);
    import drbtq_pkg::*;

    // finished-request fields stay clear unless a request completes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && phase != PH_DONE |->
            done_core == '0 && done_offset == '0 && !done_is_store && done_tag == '0)
        else $error("done fields set outside a completion");

    // a drop means the queue was full, so it cannot be empty afterwards
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dropped |-> queue_busy)
        else $error("drop reported with an empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && phase == PH_IDLE |-> !queue_busy)
        else $error("idle tick with a busy queue");

    // every transfer in yields a result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("tick transferred without a result");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(phase) && $stable(queue_busy))
        else $error("stalled result changed");

endmodule

bind dram_row_buffer_timing_queue drbtq_checker u_drbtq_checker (.*);

// ===== test/dram_row_buffer_timing_queue_tb.sv =====
`timescale 1ns / 100ps

module dram_row_buffer_timing_queue_tb;

    import drbtq_pkg::*;

    localparam int BANK_QUEUE_DEPTH = 16;

    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        req_t             req;
    } tick_t;

    typedef struct packed {
        logic [PHASE_W-1:0]  phase;
        logic [ROW_W-1:0]    row;
        logic [ROW_W-1:0]    column;
        logic [CORE_W-1:0]   core;
        logic [OFFSET_W-1:0] offset;
        logic                is_store;
        logic [TAG_W-1:0]    tag;
        logic                dropped;
        logic                busy;
    } tick_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [CMD_W-1:0]    cmd = '0;
    logic [CORE_W-1:0]   req_core = '0;
    logic [OFFSET_W-1:0] req_offset = '0;
    logic                req_is_store = 1'b0;
    logic [TAG_W-1:0]    req_tag = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [PHASE_W-1:0]  phase;
    logic [ROW_W-1:0]    shown_row;
    logic [ROW_W-1:0]    shown_column;
    logic [CORE_W-1:0]   done_core;
    logic [OFFSET_W-1:0] done_offset;
    logic                done_is_store;
    logic [TAG_W-1:0]    done_tag;
    logic                dropped;
    logic                queue_busy;
    logic                cfg_write = 1'b0;
    logic                cfg_index = CFG_ROW_DELAY;
    logic [DELAY_W-1:0]  cfg_data = '0;

    // Shadow of the bank: request FIFO, row buffer and wait counters
    req_t         bank_requests[$];
    int unsigned  row_ticks_left = 0;
    int unsigned  column_wait = 0;
    logic [ROW_W-1:0] open_row = '0;
    logic         row_is_open = 1'b0;
    logic [ROW_W-1:0] evicted_row = '0;
    int unsigned  row_delay_now = ROW_DELAY_RESET;
    int unsigned  column_delay_now = COLUMN_DELAY_RESET;

    tick_t        pending_ticks[$];
    tick_result_t expected_ticks[$];
    int unsigned  mismatches = 0;

    tick_t        on_bus = '0;
    logic         on_bus_held = 1'b0;
    int unsigned  in_gap = 0;
    int unsigned  in_calm = 0;
    int unsigned  stall_left = 0;
    int unsigned  out_calm = 0;
    logic [ROW_W-1:0] hot_rows[4];

    dram_row_buffer_timing_queue #(
        .QUEUE_DEPTH(BANK_QUEUE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cmd(cmd),
        .req_core(req_core),
        .req_offset(req_offset),
        .req_is_store(req_is_store),
        .req_tag(req_tag),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .phase(phase),
        .shown_row(shown_row),
        .shown_column(shown_column),
        .done_core(done_core),
        .done_offset(done_offset),
        .done_is_store(done_is_store),
        .done_tag(done_tag),
        .dropped(dropped),
        .queue_busy(queue_busy),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("** dram_row_buffer_timing_queue: FAILED **");
        $finish;
    end

    function automatic int unsigned idle_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Enqueue first, then time the head against the row buffer
    function automatic void time_bank_tick(tick_t t);
        tick_result_t     res;
        req_t             head;
        int unsigned      addr;
        int unsigned      col_ticks;
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] col;
        res = '0;
        col_ticks = (column_delay_now == 0) ? 1 : column_delay_now;
        if (t.cmd == CMD_APPEND || t.cmd == CMD_INSERT)
        begin
            if (bank_requests.size() >= BANK_QUEUE_DEPTH)
                res.dropped = 1'b1;
            else if (t.cmd == CMD_INSERT && bank_requests.size() != 0)
                bank_requests.insert(1, t.req);
            else
                bank_requests.insert(bank_requests.size(), t.req);
        end
        if (bank_requests.size() != 0)
        begin
            head = bank_requests[0];
            addr = int'(head.core) * PARTITION_WORDS + int'(head.offset);
            row  = ROW_W'(addr / ROW_WORDS);
            col  = ROW_W'(addr % ROW_WORDS);
            if (row_ticks_left == 0 && column_wait == 0)
            begin
                if (!row_is_open)
                begin
                    open_row       = row;
                    row_is_open    = 1'b1;
                    row_ticks_left = row_delay_now;
                end
                else if (row == open_row)
                begin
                    row_ticks_left = 0;
                end
                else
                begin
                    evicted_row    = open_row;
                    open_row       = row;
                    row_ticks_left = 2 * row_delay_now;
                end
                column_wait = col_ticks;
            end
            if (row_ticks_left > row_delay_now)
            begin
                row_ticks_left--;
                res.phase = PH_WRITE_BACK;
                res.row   = evicted_row;
            end
            else if (row_ticks_left > 0)
            begin
                row_ticks_left--;
                res.phase = PH_ROW_LOAD;
                res.row   = open_row;
            end
            else
            begin
                if (column_wait > 0)
                    column_wait--;
                res.column = col;
                if (column_wait == 0)
                begin
                    res.phase    = PH_DONE;
                    res.core     = head.core;
                    res.offset   = head.offset;
                    res.is_store = head.is_store;
                    res.tag      = head.tag;
                    void'(bank_requests.pop_front());
                end
                else
                begin
                    res.phase = PH_COLUMN;
                end
            end
        end
        res.busy = (bank_requests.size() != 0);
        expected_ticks.insert(expected_ticks.size(), res);
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endfunction

    task automatic check_tick_result();
        tick_result_t want;
        if (expected_ticks.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: result transfer with none expected, phase %0d", $time, phase);
            return;
        end
        want = expected_ticks.pop_front();
        check_field("phase", want.phase, phase);
        check_field("shown_row", want.row, shown_row);
        check_field("shown_column", want.column, shown_column);
        check_field("done_core", want.core, done_core);
        check_field("done_offset", want.offset, done_offset);
        check_field("done_is_store", want.is_store, done_is_store);
        check_field("done_tag", want.tag, done_tag);
        check_field("dropped", want.dropped, dropped);
        check_field("queue_busy", want.busy, queue_busy);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                time_bank_tick(on_bus);
                on_bus_held = 1'b0;
                if (in_calm > 0)
                begin
                    in_calm--;
                    in_gap = 0;
                end
                else
                begin
                    in_gap = idle_length();
                    if ($urandom_range(0, 39) == 0)
                        in_calm = $urandom_range(20, 80);
                end
            end
            if (!on_bus_held)
            begin
                if (in_gap > 0)
                    in_gap--;
                else if (pending_ticks.size() != 0)
                begin
                    on_bus      = pending_ticks.pop_front();
                    on_bus_held = 1'b1;
                end
            end
            in_valid     <= on_bus_held;
            cmd          <= on_bus.cmd;
            req_core     <= on_bus.req.core;
            req_offset   <= on_bus.req.offset;
            req_is_store <= on_bus.req.is_store;
            req_tag      <= on_bus.req.tag;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_tick_result();
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (out_calm > 0)
                begin
                    out_calm--;
                end
                else
                begin
                    stall_left = idle_length();
                    if ($urandom_range(0, 39) == 0)
                        out_calm = $urandom_range(20, 80);
                end
            end
        end
    end

    task automatic wait_idle();
        while (pending_ticks.size() != 0 || in_valid || expected_ticks.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_register(logic index, logic [DELAY_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (index == CFG_ROW_DELAY)
            row_delay_now = value;
        else
            column_delay_now = value;
        @(negedge clk);
    endtask

    task automatic push_tick(logic [CMD_W-1:0] c, int unsigned core, int unsigned offset,
                             logic is_store, int unsigned tag);
        tick_t t;
        t.cmd          = c;
        t.req.core     = CORE_W'(core);
        t.req.offset   = OFFSET_W'(offset);
        t.req.is_store = is_store;
        t.req.tag      = TAG_W'(tag);
        pending_ticks.insert(pending_ticks.size(), t);
    endtask

    // Settle the bank, set both delays, then queue a run of random ticks
    task automatic run_phase(int unsigned row_d, int unsigned col_d, int unsigned count,
                             int unsigned req_pct);
        tick_t            t;
        logic [ROW_W-1:0] row;
        wait_idle();
        write_register(CFG_ROW_DELAY, DELAY_W'(row_d));
        write_register(CFG_COLUMN_DELAY, DELAY_W'(col_d));
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < req_pct)
                t.cmd = ($urandom_range(0, 9) < 7) ? CMD_APPEND : CMD_INSERT;
            else
                t.cmd = ($urandom_range(0, 9) == 0) ? CMD_UNUSED : CMD_TICK;
            // Favour a few rows so hits and misses both occur
            row = ($urandom_range(0, 9) < 6) ? hot_rows[$urandom_range(0, 3)] : ROW_W'($urandom);
            t.req.core     = row[9:4];
            t.req.offset   = {row[3:0], 10'($urandom)};
            t.req.is_store = 1'($urandom);
            t.req.tag      = TAG_W'($urandom);
            pending_ticks.insert(pending_ticks.size(), t);
        end
    endtask

    initial
    begin
        for (int i = 0; i < 4; i++)
            hot_rows[i] = ROW_W'($urandom);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: idle ticks, insert into empty, extreme fields, hit then miss
        push_tick(CMD_TICK, 0, 0, 1'b0, 0);
        push_tick(CMD_UNUSED, 63, 16383, 1'b1, 31);
        push_tick(CMD_INSERT, 0, 0, 1'b0, 0);
        push_tick(CMD_APPEND, 63, 16383, 1'b1, 31);
        push_tick(CMD_INSERT, 0, 1023, 1'b1, 21);
        push_tick(CMD_APPEND, 0, 1024, 1'b0, 10);
        push_tick(CMD_APPEND, 42, 9000, 1'b1, 5);
        for (int i = 0; i < 18; i++)
            push_tick((i % 5 == 4) ? CMD_UNUSED : CMD_TICK, 0, 0, 1'b0, 0);

        run_phase(0, 1, 80, 40);
        run_phase(0, 0, 40, 50);
        run_phase(3, 1, 60, 20);
        for (int p = 0; p < 3; p++)
            run_phase($urandom_range(0, 12), $urandom_range(0, 4), 60, 20);
        run_phase(1, 255, 30, 30);
        run_phase(255, 255, 50, 60);
        run_phase(0, 1, 40, 10);

        wait_idle();
        repeat (5) @(negedge clk);
        if (mismatches == 0)
            $display("** dram_row_buffer_timing_queue: PASSED **");
        else
            $display("** dram_row_buffer_timing_queue: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/drbtq_pkg.sv
sv/drbtq_dp.sv
sv/drbtq_ctrl.sv
sv/dram_row_buffer_timing_queue.sv
sv/drbtq_checker.sv
test/dram_row_buffer_timing_queue_tb.sv
